FILE: sv/cdv_pkg.sv
// Shared types, constants and sequencer states for the central difference velocity block.
package cdv_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MASS_WIDTH = 24;
    localparam int NUM_WIDTH  = DATA_WIDTH + FRAC_BITS;
    localparam int DIFF_WIDTH = DATA_WIDTH + 1;
    localparam int PROD_WIDTH = DATA_WIDTH + MASS_WIDTH + 1;
    localparam int STEP_WIDTH = $clog2(DATA_WIDTH);

    localparam logic [MASS_WIDTH-1:0] MASS_RESET = MASS_WIDTH'(9503);

    localparam logic signed [DATA_WIDTH-1:0] VEL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] VEL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [DATA_WIDTH-1:0]        sample_time;
        logic signed [DATA_WIDTH-1:0] sample_position;
        logic                         last_sample;
    } sample_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0]        out_time;
        logic signed [DATA_WIDTH-1:0] out_position;
        logic signed [DATA_WIDTH-1:0] velocity;
        logic signed [DATA_WIDTH-1:0] momentum;
        logic                         zero_interval;
        logic                         last_result;
    } result_t;

    typedef struct packed {
        logic busy;
        logic overflow;
    } div_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_START,
        ST_DIV,
        ST_VEL,
        ST_MUL,
        ST_MOM,
        ST_EMIT_MID,
        ST_EMIT_LAST
    } seq_state_t;

endpackage

FILE: sv/cdv_divider.sv
// Iterative restoring divider giving one quotient bit per cycle, with an overflow flag.
module cdv_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [cdv_pkg::NUM_WIDTH-1:0]  numerator,
    input  logic [cdv_pkg::DATA_WIDTH-1:0] divisor,
    output cdv_pkg::div_status_t           status,
    output logic [cdv_pkg::DATA_WIDTH-1:0] quotient
);
    import cdv_pkg::*;

    logic                  busy_reg;
    logic [STEP_WIDTH-1:0] step_reg;
    logic                  overflow_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] den_reg;

    logic [DATA_WIDTH-1:0] num_high;
    logic                  start_overflow;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   trial;
    logic                  fits;
    logic [DATA_WIDTH-1:0] rem_next;

    assign num_high       = {{(DATA_WIDTH-FRAC_BITS){1'b0}},
                             numerator[NUM_WIDTH-1 -: FRAC_BITS]};
    assign start_overflow = (num_high >= divisor);
    assign shifted        = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign trial          = shifted - {1'b0, den_reg};
    assign fits           = (shifted >= {1'b0, den_reg});
    assign rem_next       = fits ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_WIDTH'(DATA_WIDTH - 1);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg      <= num_high;
            quo_reg      <= numerator[DATA_WIDTH-1:0];
            den_reg      <= divisor;
            overflow_reg <= start_overflow;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DATA_WIDTH-2:0], fits};
        end
    end

    assign status.busy     = busy_reg;
    assign status.overflow = overflow_reg;
    assign quotient        = quo_reg;

endmodule

FILE: sv/central_difference_velocity.sv
// Top level of the central difference velocity and momentum block.
//
//   Channel   Signals                            Direction  Carries
//   sample    sample_valid/ready, sample         in         one time and position sample
//   result    result_valid/ready, result         out        one velocity and momentum result
//   cfg       cfg_valid/ready, cfg_data          in         mass, unsigned Q8.16
//
// An interior sample runs through the difference, divider start, the divider's 32 quotient
// steps, velocity, multiply, momentum and emit states; a zero time span skips the divider.
// The first sample of a run returns straight to idle, the second passes the mid emit state;
// a final sample adds the last emit state. A request is taken only while the sequencer is idle;
// one result register holds output. A stalled result holds the sequencer in its emit state until
// the register frees. Reset clears the sample window and loads the default mass.
module central_difference_velocity (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  cdv_pkg::sample_t               sample,
    output logic                           result_valid,
    input  logic                           result_ready,
    output cdv_pkg::result_t               result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cdv_pkg::MASS_WIDTH-1:0] cfg_data
);
    import cdv_pkg::*;

    localparam logic signed [PROD_WIDTH-1:0] MOM_HI    = PROD_WIDTH'(VEL_MAX);
    localparam logic signed [PROD_WIDTH-1:0] MOM_LO    = PROD_WIDTH'(VEL_MIN);
    localparam logic signed [PROD_WIDTH-1:0] ROUND_ADJ =
        {{(PROD_WIDTH-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

    seq_state_t state_reg;
    seq_state_t state_next;

    logic [MASS_WIDTH-1:0]        mass_reg;
    logic [1:0]                   seen_reg;
    logic                         result_valid_reg;
    result_t                      result_reg;
    sample_t                      cur_reg;
    logic [DATA_WIDTH-1:0]        older_t_reg;
    logic signed [DATA_WIDTH-1:0] older_p_reg;
    logic [DATA_WIDTH-1:0]        mid_t_reg;
    logic signed [DATA_WIDTH-1:0] mid_p_reg;
    logic signed [DIFF_WIDTH-1:0] dt_reg;
    logic signed [DIFF_WIDTH-1:0] dp_reg;
    logic                         neg_reg;
    logic signed [DATA_WIDTH-1:0] vel_reg;
    logic signed [DATA_WIDTH-1:0] mom_reg;
    logic                         zi_reg;
    logic signed [PROD_WIDTH-1:0] prod_reg;

    logic                         sample_accept;
    logic                         out_free;
    logic                         out_load;
    logic                         div_start;
    logic                         dt_zero;
    logic [DIFF_WIDTH-1:0]        dt_mag;
    logic [DIFF_WIDTH-1:0]        dp_mag;
    logic [NUM_WIDTH-1:0]         div_num;
    div_status_t                  div_status;
    logic [DATA_WIDTH-1:0]        quotient;
    logic                         pos_sat;
    logic                         neg_sat;
    logic signed [DATA_WIDTH-1:0] vel_calc;
    logic signed [PROD_WIDTH-1:0] vel_ext;
    logic signed [PROD_WIDTH-1:0] mass_ext;
    logic signed [PROD_WIDTH-1:0] mom_adj;
    logic signed [PROD_WIDTH-1:0] mom_shift;
    logic signed [DATA_WIDTH-1:0] mom_calc;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    if (seen_reg == 2'd0)
                    begin
                        state_next = sample.last_sample ? ST_EMIT_LAST : ST_IDLE;
                    end
                    else if (seen_reg == 2'd1)
                    begin
                        state_next = ST_EMIT_MID;
                    end
                    else
                    begin
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIFF:      state_next = ST_START;
            ST_START:     state_next = dt_zero ? ST_MUL : ST_DIV;
            ST_DIV:       state_next = div_status.busy ? ST_DIV : ST_VEL;
            ST_VEL:       state_next = ST_MUL;
            ST_MUL:       state_next = ST_MOM;
            ST_MOM:       state_next = ST_EMIT_MID;
            ST_EMIT_MID:
            begin
                if (out_free)
                begin
                    state_next = cur_reg.last_sample ? ST_EMIT_LAST : ST_IDLE;
                end
            end
            ST_EMIT_LAST: state_next = out_free ? ST_IDLE : ST_EMIT_LAST;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        sample_ready = 1'b0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:                   sample_ready = 1'b1;
            ST_START:                  div_start    = !dt_zero;
            ST_EMIT_MID, ST_EMIT_LAST: out_load     = out_free;
            default:
            begin
                sample_ready = 1'b0;
            end
        endcase
    end

    assign sample_accept = sample_valid && sample_ready;
    assign out_free      = !result_valid_reg || result_ready;
    assign cfg_ready     = 1'b1;

    assign dt_zero = (dt_reg == '0);
    assign dt_mag  = dt_reg[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dt_reg) : DIFF_WIDTH'(dt_reg);
    assign dp_mag  = dp_reg[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dp_reg) : DIFF_WIDTH'(dp_reg);
    assign div_num = {dp_mag[DATA_WIDTH-1:0], {FRAC_BITS{1'b0}}};

    cdv_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (div_num),
        .divisor   (dt_mag[DATA_WIDTH-1:0]),
        .status    (div_status),
        .quotient  (quotient)
    );

    assign pos_sat  = div_status.overflow || quotient[DATA_WIDTH-1];
    assign neg_sat  = div_status.overflow
                   || (quotient[DATA_WIDTH-1] && (|quotient[DATA_WIDTH-2:0]));
    assign vel_calc = neg_reg ? (neg_sat ? VEL_MIN : -$signed(quotient))
                              : (pos_sat ? VEL_MAX : $signed(quotient));

    assign vel_ext   = PROD_WIDTH'(vel_reg);
    assign mass_ext  = $signed({{(PROD_WIDTH-MASS_WIDTH){1'b0}}, mass_reg});
    assign mom_adj   = prod_reg + (prod_reg[PROD_WIDTH-1] ? ROUND_ADJ : '0);
    assign mom_shift = mom_adj >>> FRAC_BITS;
    assign mom_calc  = (mom_shift > MOM_HI) ? VEL_MAX :
                       (mom_shift < MOM_LO) ? VEL_MIN : mom_shift[DATA_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mass_reg         <= MASS_RESET;
            seen_reg         <= 2'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                mass_reg <= cfg_data;
            end
            if (sample_accept && seen_reg == 2'd0 && !sample.last_sample)
            begin
                seen_reg <= 2'd1;
            end
            else if (state_reg == ST_EMIT_MID && out_free && !cur_reg.last_sample)
            begin
                seen_reg <= 2'd2;
            end
            else if (state_reg == ST_EMIT_LAST && out_free)
            begin
                seen_reg <= 2'd0;
            end
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            cur_reg <= sample;
            if (seen_reg == 2'd0)
            begin
                mid_t_reg <= sample.sample_time;
                mid_p_reg <= sample.sample_position;
            end
            if (seen_reg != 2'd2)
            begin
                vel_reg <= '0;
                mom_reg <= '0;
                zi_reg  <= 1'b0;
            end
        end
        unique case (state_reg)
            ST_DIFF:
            begin
                dt_reg <= $signed({1'b0, cur_reg.sample_time}) - $signed({1'b0, older_t_reg});
                dp_reg <= DIFF_WIDTH'(cur_reg.sample_position) - DIFF_WIDTH'(older_p_reg);
            end
            ST_START:
            begin
                zi_reg  <= dt_zero;
                neg_reg <= dp_reg[DIFF_WIDTH-1] ^ dt_reg[DIFF_WIDTH-1];
                if (dt_zero)
                begin
                    vel_reg <= dp_reg[DIFF_WIDTH-1] ? VEL_MIN :
                               (dp_reg == '0) ? '0 : VEL_MAX;
                end
            end
            ST_VEL:  vel_reg  <= vel_calc;
            ST_MUL:  prod_reg <= vel_ext * mass_ext;
            ST_MOM:  mom_reg  <= mom_calc;
            ST_EMIT_MID:
            begin
                if (out_free)
                begin
                    result_reg.out_time      <= mid_t_reg;
                    result_reg.out_position  <= mid_p_reg;
                    result_reg.velocity      <= vel_reg;
                    result_reg.momentum      <= mom_reg;
                    result_reg.zero_interval <= zi_reg;
                    result_reg.last_result   <= 1'b0;
                    older_t_reg              <= mid_t_reg;
                    older_p_reg              <= mid_p_reg;
                    mid_t_reg                <= cur_reg.sample_time;
                    mid_p_reg                <= cur_reg.sample_position;
                end
            end
            ST_EMIT_LAST:
            begin
                if (out_free)
                begin
                    result_reg.out_time      <= cur_reg.sample_time;
                    result_reg.out_position  <= cur_reg.sample_position;
                    result_reg.velocity      <= '0;
                    result_reg.momentum      <= '0;
                    result_reg.zero_interval <= 1'b0;
                    result_reg.last_result   <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_run_end_is_still: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_result |->
            result.velocity == '0 && result.momentum == '0 && !result.zero_interval)
        else $error("Run end result carries a non-zero velocity or momentum.");

    a_window_count: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg != 2'd3)
        else $error("Sample window count out of range.");

    a_first_sample_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        sample_accept && seen_reg == 2'd0 && !sample.last_sample |=>
            state_reg == ST_IDLE && seen_reg == 2'd1)
        else $error("First sample of a run did not return straight to idle.");

    a_zero_span_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.zero_interval |->
            result.velocity == VEL_MAX || result.velocity == VEL_MIN
            || result.velocity == '0)
        else $error("Zero time span gave an unsaturated velocity.");

endmodule
